FILE: rtl/sct_pkg.sv
// sct_pkg: shared types and constants for the sine/cosine/tangent unit
// q62 series coefficients, reduction constants, kind codes and the divider tail record
// no dependencies
`default_nettype none

package sct_pkg;

    localparam int unsigned C_FRAC_BITS  = 24;
    localparam int unsigned C_POLY_TERMS = 9;
    localparam int unsigned C_DIV_STEPS  = 33;

    localparam logic [63:0] C_Q62_ONE       = 64'h4000000000000000;
    localparam logic [63:0] C_PIO2_Q62      = 64'h6487ED5110B4611A;
    localparam logic [31:0] C_TWO_OVER_PI   = 32'hA2F9836E;
    localparam logic [31:0] C_INT32_MAX     = 32'h7FFFFFFF;
    localparam logic [31:0] C_INT32_MIN     = 32'h80000000;

    // round(2^62 / n!)
    localparam logic [63:0] C_COEF_MAG [18] = '{
        (C_Q62_ONE + 64'd1 / 2) / 64'd1,
        (C_Q62_ONE + 64'd1 / 2) / 64'd1,
        (C_Q62_ONE + 64'd2 / 2) / 64'd2,
        (C_Q62_ONE + 64'd6 / 2) / 64'd6,
        (C_Q62_ONE + 64'd24 / 2) / 64'd24,
        (C_Q62_ONE + 64'd120 / 2) / 64'd120,
        (C_Q62_ONE + 64'd720 / 2) / 64'd720,
        (C_Q62_ONE + 64'd5040 / 2) / 64'd5040,
        (C_Q62_ONE + 64'd40320 / 2) / 64'd40320,
        (C_Q62_ONE + 64'd362880 / 2) / 64'd362880,
        (C_Q62_ONE + 64'd3628800 / 2) / 64'd3628800,
        (C_Q62_ONE + 64'd39916800 / 2) / 64'd39916800,
        (C_Q62_ONE + 64'd479001600 / 2) / 64'd479001600,
        (C_Q62_ONE + 64'd6227020800 / 2) / 64'd6227020800,
        (C_Q62_ONE + 64'd87178291200 / 2) / 64'd87178291200,
        (C_Q62_ONE + 64'd1307674368000 / 2) / 64'd1307674368000,
        (C_Q62_ONE + 64'd20922789888000 / 2) / 64'd20922789888000,
        (C_Q62_ONE + 64'd355687428096000 / 2) / 64'd355687428096000
    };

    typedef logic signed [63:0] t_q62;

    typedef enum logic [1:0] {
        KIND_SIN = 2'd0,
        KIND_COS = 2'd1,
        KIND_TAN = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic        nneg;
        logic        dz;
        logic        ovf;
        logic [31:0] sc_val;
    } t_tail;

    // signed series coefficient, negative for odd term index
    function automatic t_q62 f_coef(input logic [4:0] n, input logic odd);
        t_q62 mag;
        mag = t_q62'(C_COEF_MAG[n]);
        return odd ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sct_mulq.sv
// sct_mulq: four-stage q62 multiply, rounded half away from zero, plus an addend
// built from 32x32 partial products; uses sct_pkg
`default_nettype none

module sct_mulq
    import sct_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_en,
    input  t_q62 i_a,
    input  t_q62 i_b,
    input  t_q62 i_coef,
    output t_q62 o_res
);

    logic [63:0]  w_ua;
    logic [63:0]  w_ub;
    logic [63:0]  w_m;

    logic         r_neg0;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg1;
    logic [63:0]  r_ll;
    logic [63:0]  r_lh;
    logic [63:0]  r_hl;
    logic [63:0]  r_hh;
    logic         r_neg2;
    logic [127:0] r_p;
    t_q62         r_res;

    assign w_ua = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign w_ub = i_b[63] ? 64'(-i_b) : 64'(i_b);
    assign w_m  = r_p[125:62] + {63'd0, r_p[61]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg0 <= i_a[63] ^ i_b[63];
            r_ua   <= w_ua;
            r_ub   <= w_ub;
            r_neg1 <= r_neg0;
            r_ll   <= r_ua[31:0] * r_ub[31:0];
            r_lh   <= r_ua[31:0] * r_ub[63:32];
            r_hl   <= r_ua[63:32] * r_ub[31:0];
            r_hh   <= r_ua[63:32] * r_ub[63:32];
            r_neg2 <= r_neg1;
            r_p    <= {r_hh, 64'd0} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0}
                      + {64'd0, r_ll};
            r_res  <= r_neg2 ? i_coef - t_q62'(w_m) : i_coef + t_q62'(w_m);
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: rtl/sine_cosine_tangent_unit.sv
// sine_cosine_tangent_unit: pipelined sine, cosine and tangent of a fixed-point angle
// quadrant reduction, horner series and a restoring divider; uses sct_pkg and sct_mulq
//
// usage:
//   input channel s_axis: tdata carries the angle (signed, FRAC_BITS fraction bits),
//   tuser carries the kind (0 sine, 1 cosine, 2 tangent, 3 gives zero).
//   output channel m_axis: tdata carries the value, tuser the saturation flag,
//   set when a tangent was clamped.
//   one transfer per cycle in and out while the receiver takes every result; every angle is independent.
//   the pipeline is made of the reduction stages, four stages per q62 multiply
//   along the horner chain, and the 33 stages of the one-bit-per-stage divider.
//   reset clears all valid bits; no item is in flight afterwards.
//   when the receiver stalls, the result waits in the output register and one
//   more item moves into a skid register; then the pipeline and s_axis_tready
//   hold until the receiver takes a transfer. nothing is dropped or repeated.
`default_nettype none

module sine_cosine_tangent_unit
    import sct_pkg::*;
#(
    parameter int unsigned FRAC_BITS  = C_FRAC_BITS,
    parameter int unsigned POLY_TERMS = C_POLY_TERMS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] angle
    input  wire  [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [0:0]  m_axis_tuser    // [0] saturated
);

    localparam int unsigned KW     = 32 - FRAC_BITS;
    localparam int unsigned IB     = 32 - FRAC_BITS;
    localparam int unsigned LW     = 64 + IB + 1;
    localparam int unsigned SH     = 62 - FRAC_BITS;
    localparam int unsigned NSTEP  = POLY_TERMS - 1;
    localparam int unsigned ST_R   = 5;
    localparam int unsigned ST_Z   = ST_R + 4;
    localparam int unsigned ST_SER = ST_Z + 4 * NSTEP;
    localparam int unsigned ST_S   = ST_SER + 4;
    localparam int unsigned ST_F2  = ST_S + 2;
    localparam int unsigned ST_F3  = ST_S + 3;
    localparam int unsigned ST_F4  = ST_S + 4;
    localparam int unsigned ST_R1  = ST_F4 + C_DIV_STEPS + 1;
    localparam int unsigned ST_END = ST_R1 + 1;

    logic w_en;
    logic w_in_xfer;

    // valid bits
    logic r_vld [1:ST_END];

    // reduction stages
    logic               r_s1_neg;
    logic signed [31:0] r_s1_a;
    logic [31:0]        r_s1_amag;
    logic               r_s2_neg;
    logic signed [31:0] r_s2_a;
    logic [63:0]        r_s2_prod;
    logic               r_s3_neg;
    logic signed [31:0] r_s3_a;
    logic [KW-1:0]      r_s3_kmag;
    logic               r_s4_neg;
    logic signed [31:0] r_s4_a;
    logic [63:0]        r_s4_kp;
    logic [1:0]         r_s4_quad;
    logic [63:0]        w_ksum;
    logic [KW-1:0]      w_kneg;
    logic [63:0]        w_ash;

    // side lines
    t_kind       r_kind [1:ST_F3];
    logic [1:0]  r_quad [ST_R:ST_S];
    t_q62        r_rd   [ST_R:ST_SER];
    t_q62        r_zd   [ST_Z+1:ST_SER-4];
    t_q62        r_cd   [ST_SER+1:ST_S];

    // series
    t_q62 w_z;
    t_q62 w_s;
    t_q62 w_sacc [0:NSTEP];
    t_q62 w_cacc [0:NSTEP];
    t_q62 w_zin  [1:NSTEP];

    // selection and rounding
    logic [1:0]  w_f1_q;
    t_q62        w_f1_v;
    t_q62        w_c;
    t_q62        r_f1_v;
    t_q62        r_f1_num;
    t_q62        r_f1_den;
    logic        r_f2_vneg;
    logic [63:0] r_f2_vm;
    logic [63:0] r_f2_un;
    logic [63:0] r_f2_ud;
    logic        r_f2_nneg;
    logic        r_f2_neg;
    logic [63:0] w_f3_rnd;
    logic [32:0] w_f3_m;
    logic [31:0] r_f3_val;
    logic [LW-1:0] r_f3_lim;
    logic [63:0] r_f3_un;
    logic [63:0] r_f3_ud;
    logic        r_f3_nneg;
    logic        r_f3_neg;
    logic        r_f3_dz;

    // divider
    logic [63:0] r_dp  [0:C_DIV_STEPS];
    logic [32:0] r_dl  [0:C_DIV_STEPS-1];
    logic [32:0] r_dq  [0:C_DIV_STEPS];
    logic [63:0] r_dud [0:C_DIV_STEPS];
    t_tail       r_dt  [0:C_DIV_STEPS];

    // final stages
    logic        w_r1_rb;
    logic [33:0] r_r1_m;
    t_tail       r_r1_t;
    logic [33:0] w_negm;
    logic [31:0] n_end_val;
    logic        n_end_sat;
    logic [31:0] r_end_val;
    logic        r_end_sat;

    // output register and skid
    logic        r_out_v;
    logic [31:0] r_out_val;
    logic        r_out_sat;
    logic        r_skid_v;
    logic [31:0] r_skid_val;
    logic        r_skid_sat;
    logic        n_out_v;
    logic [31:0] n_out_val;
    logic        n_out_sat;
    logic        n_skid_v;
    logic [31:0] n_skid_val;
    logic        n_skid_sat;
    logic        w_take;

    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;
    assign w_in_xfer     = s_axis_tvalid && w_en;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[1] <= 1'b0;
        end else if (w_en) begin
            r_vld[1] <= w_in_xfer;
        end
    end

    for (genvar k = 2; k <= ST_END; k++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // angle reduction
    assign w_ksum = r_s2_prod + (64'd1 << (FRAC_BITS + 31));
    assign w_kneg = KW'(0) - r_s3_kmag;
    assign w_ash  = 64'($signed(r_s4_a)) << SH;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_neg  <= s_axis_tdata[31];
            r_s1_a    <= $signed(s_axis_tdata);
            r_s1_amag <= s_axis_tdata[31] ? 32'd0 - s_axis_tdata : s_axis_tdata;
            r_s2_neg  <= r_s1_neg;
            r_s2_a    <= r_s1_a;
            r_s2_prod <= 64'(r_s1_amag) * 64'(C_TWO_OVER_PI);
            r_s3_neg  <= r_s2_neg;
            r_s3_a    <= r_s2_a;
            r_s3_kmag <= KW'(w_ksum >> (FRAC_BITS + 32));
            r_s4_neg  <= r_s3_neg;
            r_s4_a    <= r_s3_a;
            r_s4_kp   <= 64'(r_s3_kmag) * C_PIO2_Q62;
            r_s4_quad <= r_s3_neg ? w_kneg[1:0] : r_s3_kmag[1:0];
            r_rd[ST_R] <= t_q62'(r_s4_neg ? w_ash + r_s4_kp : w_ash - r_s4_kp);
            r_quad[ST_R] <= r_s4_quad;
            r_kind[1] <= t_kind'(s_axis_tuser);
        end
    end

    for (genvar k = 2; k <= ST_F3; k++) begin : g_kind
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_kind[k] <= r_kind[k-1];
            end
        end
    end

    for (genvar k = ST_R + 1; k <= ST_S; k++) begin : g_quad
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_quad[k] <= r_quad[k-1];
            end
        end
    end

    for (genvar k = ST_R + 1; k <= ST_SER; k++) begin : g_rd
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rd[k] <= r_rd[k-1];
            end
        end
    end

    // z = r * r
    sct_mulq u_mul_z (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_a    (r_rd[ST_R]),
        .i_b    (r_rd[ST_R]),
        .i_coef (t_q62'(0)),
        .o_res  (w_z)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zd[ST_Z+1] <= w_z;
        end
    end

    for (genvar k = ST_Z + 2; k <= ST_SER - 4; k++) begin : g_zd
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_zd[k] <= r_zd[k-1];
            end
        end
    end

    // horner chains for sine and cosine series
    assign w_sacc[0] = f_coef(5'(2 * NSTEP + 1), NSTEP[0]);
    assign w_cacc[0] = f_coef(5'(2 * NSTEP), NSTEP[0]);

    for (genvar j = 1; j <= NSTEP; j++) begin : g_horner
        localparam int unsigned TI = NSTEP - j;

        if (j == 1) begin : g_first
            assign w_zin[j] = w_z;
        end else begin : g_next
            assign w_zin[j] = r_zd[ST_Z + 4 * (j - 1)];
        end

        sct_mulq u_mul_sin (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_a    (w_zin[j]),
            .i_b    (w_sacc[j-1]),
            .i_coef (f_coef(5'(2 * TI + 1), TI[0])),
            .o_res  (w_sacc[j])
        );

        sct_mulq u_mul_cos (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_a    (w_zin[j]),
            .i_b    (w_cacc[j-1]),
            .i_coef (f_coef(5'(2 * TI), TI[0])),
            .o_res  (w_cacc[j])
        );
    end

    // s = r * sine series
    sct_mulq u_mul_s (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_a    (r_rd[ST_SER]),
        .i_b    (w_sacc[NSTEP]),
        .i_coef (t_q62'(0)),
        .o_res  (w_s)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cd[ST_SER+1] <= w_cacc[NSTEP];
        end
    end

    for (genvar k = ST_SER + 2; k <= ST_S; k++) begin : g_cd
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cd[k] <= r_cd[k-1];
            end
        end
    end

    // quadrant selection
    assign w_c    = r_cd[ST_S];
    assign w_f1_q = r_quad[ST_S] + 2'(r_kind[ST_S]);
    assign w_f1_v = w_f1_q[0] ? w_c : w_s;

    // rounding of sine and cosine
    assign w_f3_rnd = r_f2_vm + (64'd1 << (SH - 1));
    assign w_f3_m   = 33'(w_f3_rnd >> SH);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_v    <= w_f1_q[1] ? -w_f1_v : w_f1_v;
            r_f1_num  <= r_quad[ST_S][0] ? -w_c : w_s;
            r_f1_den  <= r_quad[ST_S][0] ? w_s : w_c;
            r_f2_vneg <= r_f1_v[63];
            r_f2_vm   <= r_f1_v[63] ? 64'(-r_f1_v) : 64'(r_f1_v);
            r_f2_un   <= r_f1_num[63] ? 64'(-r_f1_num) : 64'(r_f1_num);
            r_f2_ud   <= r_f1_den[63] ? 64'(-r_f1_den) : 64'(r_f1_den);
            r_f2_nneg <= r_f1_num[63];
            r_f2_neg  <= r_f1_num[63] ^ r_f1_den[63];
            r_f3_val  <= r_f2_vneg ? 32'(33'd0 - w_f3_m) : w_f3_m[31:0];
            r_f3_lim  <= (LW'(r_f2_ud) << IB) + LW'(r_f2_ud);
            r_f3_un   <= r_f2_un;
            r_f3_ud   <= r_f2_ud;
            r_f3_nneg <= r_f2_nneg;
            r_f3_neg  <= r_f2_neg;
            r_f3_dz   <= (r_f2_ud == 64'd0);
        end
    end

    // divider entry
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dp[0]         <= r_f3_un >> (33 - FRAC_BITS);
            r_dl[0]         <= {r_f3_un[32-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
            r_dq[0]         <= 33'd0;
            r_dud[0]        <= r_f3_ud;
            r_dt[0].kind    <= r_kind[ST_F3];
            r_dt[0].neg     <= r_f3_neg;
            r_dt[0].nneg    <= r_f3_nneg;
            r_dt[0].dz      <= r_f3_dz;
            r_dt[0].ovf     <= (LW'(r_f3_un) >= r_f3_lim);
            r_dt[0].sc_val  <= r_f3_val;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar i = 1; i <= C_DIV_STEPS; i++) begin : g_div
        logic [64:0] w_p2;
        logic [64:0] w_diff;
        logic        w_ge;

        assign w_p2   = {r_dp[i-1], r_dl[i-1][32]};
        assign w_diff = w_p2 - {1'b0, r_dud[i-1]};
        assign w_ge   = (w_p2 >= {1'b0, r_dud[i-1]});

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dp[i]  <= w_ge ? w_diff[63:0] : w_p2[63:0];
                r_dq[i]  <= {r_dq[i-1][31:0], w_ge};
                r_dud[i] <= r_dud[i-1];
                r_dt[i]  <= r_dt[i-1];
            end
        end

        if (i < C_DIV_STEPS) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dl[i] <= {r_dl[i-1][31:0], 1'b0};
                end
            end
        end
    end

    // final rounding and clamping
    assign w_r1_rb = ({r_dp[C_DIV_STEPS], 1'b0} >= {1'b0, r_dud[C_DIV_STEPS]});
    assign w_negm  = 34'd0 - r_r1_m;

    always_comb begin
        n_end_val = 32'd0;
        n_end_sat = 1'b0;
        unique case (r_r1_t.kind)
            KIND_SIN, KIND_COS: begin
                n_end_val = r_r1_t.sc_val;
            end
            KIND_TAN: begin
                priority if (r_r1_t.dz) begin
                    n_end_sat = 1'b1;
                    n_end_val = r_r1_t.nneg ? C_INT32_MIN : C_INT32_MAX;
                end else if (r_r1_t.ovf) begin
                    n_end_sat = 1'b1;
                    n_end_val = r_r1_t.neg ? C_INT32_MIN : C_INT32_MAX;
                end else if (!r_r1_t.neg && r_r1_m > {2'b00, C_INT32_MAX}) begin
                    n_end_sat = 1'b1;
                    n_end_val = C_INT32_MAX;
                end else if (r_r1_t.neg && r_r1_m > {2'b00, C_INT32_MIN}) begin
                    n_end_sat = 1'b1;
                    n_end_val = C_INT32_MIN;
                end else begin
                    n_end_val = r_r1_t.neg ? w_negm[31:0] : r_r1_m[31:0];
                end
            end
            default: begin
                n_end_val = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1_m    <= {1'b0, r_dq[C_DIV_STEPS]} + {33'd0, w_r1_rb};
            r_r1_t    <= r_dt[C_DIV_STEPS];
            r_end_val <= n_end_val;
            r_end_sat <= n_end_sat;
        end
    end

    // output register with skid
    assign w_take = r_out_v && m_axis_tready;

    always_comb begin
        n_out_v    = r_out_v;
        n_out_val  = r_out_val;
        n_out_sat  = r_out_sat;
        n_skid_v   = r_skid_v;
        n_skid_val = r_skid_val;
        n_skid_sat = r_skid_sat;
        priority if (r_skid_v) begin
            if (w_take) begin
                n_out_val = r_skid_val;
                n_out_sat = r_skid_sat;
                n_skid_v  = 1'b0;
            end
        end else if (r_vld[ST_END]) begin
            if (!r_out_v || w_take) begin
                n_out_v   = 1'b1;
                n_out_val = r_end_val;
                n_out_sat = r_end_sat;
            end else begin
                n_skid_v   = 1'b1;
                n_skid_val = r_end_val;
                n_skid_sat = r_end_sat;
            end
        end else if (w_take) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out_val  <= n_out_val;
        r_out_sat  <= n_out_sat;
        r_skid_val <= n_skid_val;
        r_skid_sat <= n_skid_sat;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_val;
    assign m_axis_tuser  = r_out_sat;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench: self-checking bench for sine_cosine_tangent_unit, one sine/cosine/tangent per transfer
// bit-exact q62 predictor, random bursts on input and stalls on output; uses sct_pkg and the rtl
`default_nettype none

module testbench;
    import sct_pkg::*;

    typedef struct {
        logic [31:0] value;
        logic        saturated;
    } t_trig_result;

    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int signed   PIO2_LSB   = 26353589;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] angle
    logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] value
    logic [0:0]  m_axis_tuser;        // [0] saturated

    t_trig_result expected_q[$];
    int unsigned  error_count = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  burst_left = 0;
    logic         hold_output = 1'b0;
    int unsigned  stall_mode = 0;

    sine_cosine_tangent_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] factorial(input int n);
        logic [63:0] f;
        f = 64'd1;
        for (int j = 2; j <= n; j++) f = f * j;
        return f;
    endfunction

    function automatic logic signed [63:0] q62_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic        neg;
        logic [63:0] ua, ub, m;
        logic [127:0] p;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        m = p[125:62] + {63'd0, p[61]};
        return neg ? -m : m;
    endfunction

    function automatic logic signed [63:0] taylor_coef(input int n, input int i);
        logic [63:0] f, c;
        f = factorial(n);
        c = (64'h4000000000000000 + f / 2) / f;
        return (i % 2) ? -c : c;
    endfunction

    function automatic logic signed [63:0] horner(input logic signed [63:0] z, input int off);
        logic signed [63:0] acc;
        acc = taylor_coef(2 * (C_POLY_TERMS - 1) + off, C_POLY_TERMS - 1);
        for (int i = C_POLY_TERMS - 2; i >= 0; i--)
            acc = taylor_coef(2 * i + off, i) + q62_mul(z, acc);
        return acc;
    endfunction

    function automatic logic [31:0] round_to_out(input logic signed [63:0] v);
        logic [63:0] m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << (61 - C_FRAC_BITS))) >> (62 - C_FRAC_BITS);
        return (v < 0) ? 32'(-m) : 32'(m);
    endfunction

    function automatic t_trig_result predict_trig(input logic [1:0] kind,
                                                  input logic [31:0] angle);
        t_trig_result       res;
        logic signed [63:0] a, k, r, z, s, c, v, num, den;
        logic [63:0]        amag, kmag, un, ud, ip, rem, m;
        logic [1:0]         quad, q;
        logic               neg;
        res.value = '0;
        res.saturated = 1'b0;
        a = {{32{angle[31]}}, angle};
        amag = (a < 0) ? -a : a;
        kmag = (amag * 64'(C_TWO_OVER_PI) + (64'd1 << (C_FRAC_BITS + 31))) >> (C_FRAC_BITS + 32);
        k = (a < 0) ? -kmag : kmag;
        quad = k[1:0];
        r = (a <<< (62 - C_FRAC_BITS)) - k * C_PIO2_Q62;
        z = q62_mul(r, r);
        s = q62_mul(r, horner(z, 1));
        c = horner(z, 0);
        if (kind == KIND_SIN || kind == KIND_COS) begin
            q = quad + kind;
            v = q[0] ? c : s;
            if (q[1]) v = -v;
            res.value = round_to_out(v);
        end else if (kind == KIND_TAN) begin
            num = quad[0] ? -c : s;
            den = quad[0] ? s : c;
            neg = (num < 0) != (den < 0);
            un = (num < 0) ? -num : num;
            ud = (den < 0) ? -den : den;
            if (ud == 0) begin
                res.saturated = 1'b1;
                res.value = (num < 0) ? C_INT32_MIN : C_INT32_MAX;
            end else begin
                ip = un / ud;
                if (ip > (64'd1 << (32 - C_FRAC_BITS))) begin
                    res.saturated = 1'b1;
                    res.value = neg ? C_INT32_MIN : C_INT32_MAX;
                end else begin
                    rem = un % ud;
                    m = ip;
                    for (int b = 0; b < C_FRAC_BITS; b++) begin
                        rem = rem << 1;
                        m = m << 1;
                        if (rem >= ud) begin
                            rem = rem - ud;
                            m[0] = 1'b1;
                        end
                    end
                    if ((rem << 1) >= ud) m = m + 1;
                    if (!neg && m > 64'h7FFFFFFF) begin
                        res.saturated = 1'b1;
                        res.value = C_INT32_MAX;
                    end else if (neg && m > 64'h80000000) begin
                        res.saturated = 1'b1;
                        res.value = C_INT32_MIN;
                    end else begin
                        res.value = neg ? 32'(-m) : 32'(m);
                    end
                end
            end
        end
        return res;
    endfunction

    // ---------------- monitor and checker ----------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("error: %s got %h expected %h", what, got, want);
        error_count++;
    endtask

    always @(negedge i_clk) begin
        t_trig_result want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("sine_cosine_tangent_unit: mismatch");
                $finish;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(predict_trig(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transfer", m_axis_tdata, 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata !== want.value)
                        report_mismatch("value", m_axis_tdata, want.value);
                    if (m_axis_tuser[0] !== want.saturated)
                        report_mismatch("saturated", {31'd0, m_axis_tuser[0]},
                                        {31'd0, want.saturated});
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (($urandom & 63) == 0) stall_mode <= $urandom_range(0, 3);
        if (hold_output)
            m_axis_tready <= 1'b0;
        else if (stall_mode == 0)
            m_axis_tready <= 1'b1;
        else if (stall_mode == 1)
            m_axis_tready <= ($urandom & 3) != 0;
        else if (stall_mode == 2)
            m_axis_tready <= ($urandom & 1) != 0;
        else
            m_axis_tready <= ($urandom & 7) == 0;
    end

    // ---------------- stimulus ----------------
    task automatic send_angle(input logic [1:0] kind, input logic [31:0] angle);
        int unsigned gap;
        logic        ok;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = (($urandom & 7) == 0) ? 80 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= angle;
        do begin
            @(negedge i_clk);
            ok = s_axis_tready;
            @(posedge i_clk);
        end while (!ok);
    endtask

    function automatic logic [1:0] random_kind();
        return (($urandom & 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    endfunction

    function automatic logic [31:0] random_angle();
        int signed kq;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'($signed($urandom_range(0, 32'h0C000000)) - 32'sh06000000);
            default: begin
                kq = $signed($urandom_range(0, 160)) - 80;
                return 32'(kq * PIO2_LSB + $signed($urandom_range(0, 128)) - 64);
            end
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] angles[10];
        angles = '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF,
                   32'(PIO2_LSB), 32'(-PIO2_LSB), 32'(PIO2_LSB / 2), 32'(PIO2_LSB / 2 + 1),
                   32'(3 * PIO2_LSB)};
        foreach (angles[i]) begin
            send_angle(KIND_SIN, angles[i]);
            send_angle(KIND_TAN, angles[i]);
        end
        send_angle(KIND_COS, 32'h7FFFFFFF);
        send_angle(KIND_COS, 32'h80000000);
        send_angle(2'd3, 32'h12345678);
        send_angle(KIND_COS, 32'(2 * PIO2_LSB));
    endtask

    task automatic test_random(input int n);
        repeat (n) send_angle(random_kind(), random_angle());
    endtask

    task automatic test_output_hold();
        fork
            begin
                hold_output = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_output = 1'b0;
            end
            test_random(150);
        join
    endtask

    task automatic test_drain_pause();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        test_random(20);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);
        test_output_hold();
        test_drain_pause();
        test_random(180);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("sine_cosine_tangent_unit: match");
        else
            $display("sine_cosine_tangent_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
